FILE: rtl/core/bmpdec_pkg.sv
package bmpdec_pkg;

    localparam int DEFAULT_MAX_DIM = 4096;
    localparam int CHAN_W          = 8;
    localparam int COORD_W         = 12;
    localparam int HDR_W           = 32;

    // header byte positions
    localparam logic [HDR_W-1:0] POS_OFFSET_LO = 32'd10;
    localparam logic [HDR_W-1:0] POS_OFFSET_HI = 32'd13;
    localparam logic [HDR_W-1:0] POS_WIDTH_LO  = 32'd18;
    localparam logic [HDR_W-1:0] POS_WIDTH_HI  = 32'd21;
    localparam logic [HDR_W-1:0] POS_HEIGHT_LO = 32'd22;
    localparam logic [HDR_W-1:0] POS_HEIGHT_HI = 32'd25;
    localparam logic [HDR_W-1:0] POS_BPP_LO    = 32'd28;
    localparam logic [HDR_W-1:0] POS_BPP_HI    = 32'd29;
    localparam logic [HDR_W-1:0] MIN_OFFSET    = 32'd30;

    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_PIXEL  = 5'b00100,
        PH_PAD    = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic               last_pixel;
        logic               format_error;
    } t_result;

endpackage

FILE: rtl/core/bmpdec_parser.sv
module bmpdec_parser #(
    parameter int MAX_DIM = bmpdec_pkg::DEFAULT_MAX_DIM
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [7:0]              i_byte_value,
    input  logic                    i_start_of_file,
    output logic                    o_res_valid,
    output bmpdec_pkg::t_result     o_res
);

    localparam int HDR_W = bmpdec_pkg::HDR_W;
    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = ($clog2(MAX_DIM + 1) < 2) ? 2 : $clog2(MAX_DIM + 1);
    localparam int CW    = bmpdec_pkg::COORD_W;
    localparam logic [HDR_W-1:0] MAX_DIM_V = HDR_W'(MAX_DIM);
    localparam logic [HDR_W-1:0] POS_MAX   = '1;

    bmpdec_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [HDR_W-1:0]   r_pos, n_pos, cur_pos;
    logic [HDR_W-1:0]   r_data_start, n_data_start;
    logic [HDR_W-1:0]   r_width, n_width;
    logic [HDR_W-1:0]   r_height, n_height;
    logic [31:0]        r_gather, n_gather;
    logic               r_is32, n_is32;
    logic [1:0]         r_bip, n_bip;
    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [1:0]         r_pad, n_pad;

    logic [31:0]        pix_g;
    logic               pix_end;
    logic [DIM_W-1:0]   col_p1, row_p1, w_n, h_n;
    logic               pix_last;
    logic               do_pixel;
    logic [15:0]        bpp;
    logic               hdr_ok;
    logic [CNT_W+CW-1:0] col_ext, row_ext;
    logic [1:0]         lane;

    always_comb begin
        cur_phase = i_start_of_file ? bmpdec_pkg::PH_HEADER : r_phase;
        cur_pos   = i_start_of_file ? '0 : r_pos;

        // byte lane of the current pixel byte
        pix_g = r_gather;
        pix_g[8*r_bip +: 8] = i_byte_value;
        pix_end = r_is32 ? (r_bip == 2'd3) : (r_bip == 2'd2);
        w_n      = r_width[DIM_W-1:0];
        h_n      = r_height[DIM_W-1:0];
        col_p1   = DIM_W'(r_col) + DIM_W'(1);
        row_p1   = DIM_W'(r_row) + DIM_W'(1);
        pix_last = (col_p1 == w_n) && (row_p1 == h_n);
        col_ext  = {{CW{1'b0}}, r_col};
        row_ext  = {{CW{1'b0}}, r_row};

        bpp    = {i_byte_value, r_gather[7:0]};
        hdr_ok = (r_width >= HDR_W'(1)) && (r_width <= MAX_DIM_V)
              && (r_height >= HDR_W'(1)) && (r_height <= MAX_DIM_V)
              && (r_data_start >= bmpdec_pkg::MIN_OFFSET)
              && ((bpp == bmpdec_pkg::BPP_24) || (bpp == bmpdec_pkg::BPP_32));

        n_phase      = cur_phase;
        n_pos        = (cur_pos == POS_MAX) ? cur_pos : cur_pos + HDR_W'(1);
        n_data_start = r_data_start;
        n_width      = r_width;
        n_height     = r_height;
        n_gather     = r_gather;
        n_is32       = r_is32;
        n_bip        = r_bip;
        n_col        = r_col;
        n_row        = r_row;
        n_pad        = r_pad;
        o_res_valid  = 1'b0;
        o_res        = '0;
        do_pixel     = 1'b0;
        lane         = cur_pos[1:0] - 2'd2;

        unique case (cur_phase)
            bmpdec_pkg::PH_HEADER: begin
                // each field byte lands in its own lane, positions come in order
                if (cur_pos >= bmpdec_pkg::POS_OFFSET_LO && cur_pos <= bmpdec_pkg::POS_OFFSET_HI)
                    n_data_start[8*lane +: 8] = i_byte_value;
                else if (cur_pos >= bmpdec_pkg::POS_WIDTH_LO
                         && cur_pos <= bmpdec_pkg::POS_WIDTH_HI)
                    n_width[8*lane +: 8] = i_byte_value;
                else if (cur_pos >= bmpdec_pkg::POS_HEIGHT_LO
                         && cur_pos <= bmpdec_pkg::POS_HEIGHT_HI)
                    n_height[8*lane +: 8] = i_byte_value;
                else if (cur_pos == bmpdec_pkg::POS_BPP_LO)
                    n_gather[7:0] = i_byte_value;

                if (cur_pos == bmpdec_pkg::POS_BPP_HI) begin
                    if (!hdr_ok) begin
                        o_res_valid        = 1'b1;
                        o_res.format_error = 1'b1;
                        n_phase            = bmpdec_pkg::PH_DONE;
                    end else begin
                        n_is32  = (bpp == bmpdec_pkg::BPP_32);
                        n_bip   = 2'd0;
                        n_col   = '0;
                        n_row   = '0;
                        n_pad   = 2'd0;
                        n_phase = bmpdec_pkg::PH_SKIP;
                    end
                end
            end
            bmpdec_pkg::PH_SKIP: begin
                if (cur_pos >= r_data_start) begin
                    n_phase  = bmpdec_pkg::PH_PIXEL;
                    do_pixel = 1'b1;
                end
            end
            bmpdec_pkg::PH_PIXEL: begin
                do_pixel = 1'b1;
            end
            bmpdec_pkg::PH_PAD: begin
                n_pad = r_pad - 2'd1;
                if (n_pad == 2'd0)
                    n_phase = bmpdec_pkg::PH_PIXEL;
            end
            bmpdec_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (do_pixel) begin
            if (!pix_end) begin
                n_gather = pix_g;
                n_bip    = r_bip + 2'd1;
            end else begin
                o_res_valid = 1'b1;
                if (r_is32) begin
                    o_res.red   = pix_g[31:24];
                    o_res.green = pix_g[23:16];
                    o_res.blue  = pix_g[15:8];
                    o_res.alpha = pix_g[7:0];
                end else begin
                    o_res.red   = pix_g[23:16];
                    o_res.green = pix_g[15:8];
                    o_res.blue  = pix_g[7:0];
                    o_res.alpha = bmpdec_pkg::ALPHA_OPAQUE;
                end
                o_res.pixel_column = col_ext[CW-1:0];
                o_res.pixel_row    = row_ext[CW-1:0];
                o_res.last_pixel   = pix_last;
                n_bip = 2'd0;
                if (pix_last) begin
                    n_phase = bmpdec_pkg::PH_DONE;
                end else if (col_p1 == w_n) begin
                    n_col = '0;
                    n_row = row_p1[CNT_W-1:0];
                    // 24-bit rows pad by width mod 4, 32-bit rows never pad
                    n_pad   = r_is32 ? 2'd0 : w_n[1:0];
                    n_phase = (n_pad != 2'd0) ? bmpdec_pkg::PH_PAD : bmpdec_pkg::PH_PIXEL;
                end else begin
                    n_col = col_p1[CNT_W-1:0];
                end
            end
        end

        o_res_valid = o_res_valid & i_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bmpdec_pkg::PH_HEADER;
            r_pos   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_start <= n_data_start;
            r_width      <= n_width;
            r_height     <= n_height;
            r_gather     <= n_gather;
            r_is32       <= n_is32;
            r_bip        <= n_bip;
            r_col        <= n_col;
            r_row        <= n_row;
            r_pad        <= n_pad;
        end
    end

endmodule

FILE: rtl/core/bmp_stream_pixel_decoder_core.sv
// output: a pixel is registered into the output stage from the byte that completes it
// throughput: one file byte per cycle while o_stall is low; the byte path is a single registered pass
// at most one pixel per byte, so the two-entry output stage never throttles a ready sink
// reset: i_rst_n is synchronous, active low; the parse returns to the header and the
// output stage empties; the next byte counts as byte 0 of a file
module bmp_stream_pixel_decoder_core #(
    parameter int MAX_DIM = bmpdec_pkg::DEFAULT_MAX_DIM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_start_of_file,
    // pixel output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [11:0] o_pixel_column,
    output logic [11:0] o_pixel_row,
    output logic        o_last_pixel,
    output logic        o_format_error
);

    // input transaction taken this cycle
    logic                in_accept;
    // parser result, valid only for an accepted transaction
    logic                res_valid;
    bmpdec_pkg::t_result res;

    // output register plus skid entry
    logic                r_out_valid;
    bmpdec_pkg::t_result r_out;
    logic                r_skid_valid;
    bmpdec_pkg::t_result r_skid;
    logic                out_free;

    // stall only once the skid entry is occupied, so the input side never
    // waits on the sink combinationally
    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;

    bmpdec_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (in_accept),
        .i_byte_value    (i_byte_value),
        .i_start_of_file (i_start_of_file),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // output register empties this edge, or is already empty
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // skid entry goes first; no new result can arrive while it is full
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            // sink is stalled, park the new result
            r_skid_valid <= 1'b1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid)
                r_out <= r_skid;
            else if (res_valid)
                r_out <= res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_alpha        = r_out.alpha;
    assign o_pixel_column = r_out.pixel_column;
    assign o_pixel_row    = r_out.pixel_row;
    assign o_last_pixel   = r_out.last_pixel;
    assign o_format_error = r_out.format_error;

endmodule
